/* src/power_sample_lag_correction_top_assert.svh */
// Assertion macros for the lag-correction block.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef POWER_SAMPLE_LAG_CORRECTION_TOP_ASSERT_SVH
`define POWER_SAMPLE_LAG_CORRECTION_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define PSLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define PSLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pslc_pkg.sv */
// Shared constants, register codes and state type of the lag-correction block.
// No dependencies.
package pslc_pkg;

  // Field widths
  localparam int POWER_BITS_DEF = 20;
  localparam int CAP_BITS       = 24;
  localparam int TIME_BITS      = 63;
  localparam int SUM_BITS       = 63;
  localparam int INTERVAL_BITS  = 35;
  localparam int TALLY_BITS     = 32;
  localparam int FILL_BITS      = 3;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 32;

  // Reset values; power values get cut to the power width at the user
  localparam logic [CAP_BITS-1:0]      CAP_RESET       = 24'd840000;
  localparam logic [31:0]              MAX_POWER_RESET = 32'd1048575;
  localparam logic [31:0]              IDLE_RESET      = 32'd45000;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET  = 35'd30000000000;

  // History fill levels
  localparam logic [FILL_BITS-1:0] FILL_CORRECT = 3'd2;  // correction possible
  localparam logic [FILL_BITS-1:0] FILL_COUNTED = 3'd4;  // totals are updated
  localparam logic [FILL_BITS-1:0] FILL_MAX     = 3'd5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CAPACITANCE = 2'd0,
    REG_MAX_POWER   = 2'd1,
    REG_ACTIVE_IDLE = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_CORR,
    S_CLAMP,
    S_CHECK,
    S_MUL,
    S_DONE
  } lag_state_t;

endpackage

/* src/pslc_if.sv */
// Handshake channels of the lag-correction block: samples, results, config.
// Depends on pslc_pkg.
interface pslc_in_if
  import pslc_pkg::*;
#(
  parameter int POWER_BITS = POWER_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [POWER_BITS-1:0] power_mw;
  logic [TIME_BITS-1:0]  time_ns;

  modport source (output valid, power_mw, time_ns, input ready);
  modport sink   (input valid, power_mw, time_ns, output ready);
endinterface

interface pslc_out_if
  import pslc_pkg::*;
#(
  parameter int POWER_BITS = POWER_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     corrected_valid;
  logic [POWER_BITS-1:0]    corrected_power_mw;
  logic                     is_active;
  logic                     divide_fault;
  logic [TIME_BITS-1:0]     active_time_ns;
  logic [SUM_BITS-1:0]      active_energy;
  logic [INTERVAL_BITS-1:0] min_interval_ns;
  logic [TALLY_BITS-1:0]    active_count;
  logic [TALLY_BITS-1:0]    discarded_count;

  modport source (output valid, corrected_valid, corrected_power_mw, is_active,
                  divide_fault, active_time_ns, active_energy, min_interval_ns,
                  active_count, discarded_count, input ready);
  modport sink   (input valid, corrected_valid, corrected_power_mw, is_active,
                  divide_fault, active_time_ns, active_energy, min_interval_ns,
                  active_count, discarded_count, output ready);
endinterface

interface pslc_cfg_if
  import pslc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/power_sample_lag_correction_top.sv */
// Top level of the lag-correction block: sequencer, history, totals, output register.
// Depends on pslc_pkg, pslc_if, pslc_ser_div, pslc_ser_mul and the assert header.

// Each power sample beat yields exactly one result beat. The block works on one
// sample at a time; a result waits in an output register, so the next sample is
// taken while the sink stalls. The first two samples only load history. A
// corrected sample that is not counted as active passes through the serial
// divider of the correction term, one quotient bit per cycle; one that is
// counted as active then also passes through the serial multiplier for interval
// times power, one power bit per cycle. A zero time span sets divide_fault and
// drops the correction term. The configuration port is always ready; write it
// only while no sample is in flight.
module power_sample_lag_correction_top
  import pslc_pkg::*;
#(
  parameter int POWER_BITS = POWER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pslc_in_if.sink           in_chan,
  pslc_out_if.source        out_chan,
  pslc_cfg_if.sink          cfg_chan
);

  localparam int NUM_BITS = CAP_BITS + POWER_BITS;

  lag_state_t state_r, state_nxt;

  // Configuration
  logic [CAP_BITS-1:0]   cap_r;
  logic [POWER_BITS-1:0] max_r;
  logic [POWER_BITS-1:0] idle_r;

  // Sample history
  logic [POWER_BITS-1:0] older_p_r, newer_p_r;
  logic [TIME_BITS-1:0]  older_t_r, newer_t_r;
  logic [FILL_BITS-1:0]  fill_r;

  // Current sample and its spans
  logic [POWER_BITS-1:0] p_r;
  logic [TIME_BITS-1:0]  t_r;
  logic [POWER_BITS-1:0] dp_r;
  logic                  dp_neg_r;
  logic [TIME_BITS-1:0]  dt_r;
  logic                  dt_neg_r;

  // Correction
  logic [NUM_BITS:0]     raw_r;
  logic                  zero_r;
  logic                  fault_r;
  logic [POWER_BITS-1:0] corr_r;
  logic                  act_r;
  logic [TIME_BITS-1:0]  iv_r;

  // Totals
  logic [TIME_BITS-1:0]     time_sum_r;
  logic [SUM_BITS-1:0]      energy_r;
  logic [INTERVAL_BITS-1:0] min_r;
  logic [TALLY_BITS-1:0]    act_cnt_r;
  logic [TALLY_BITS-1:0]    disc_cnt_r;

  // Output register
  logic                     out_valid_r;
  logic                     o_corr_valid_r;
  logic [POWER_BITS-1:0]    o_corr_r;
  logic                     o_act_r;
  logic                     o_fault_r;
  logic [TIME_BITS-1:0]     o_time_r;
  logic [SUM_BITS-1:0]      o_energy_r;
  logic [INTERVAL_BITS-1:0] o_min_r;
  logic [TALLY_BITS-1:0]    o_act_cnt_r;
  logic [TALLY_BITS-1:0]    o_disc_cnt_r;

  // Control strobes
  logic in_ready;
  logic in_beat;
  logic div_start;
  logic mul_start;
  logic out_load;
  logic count_active;

  // Datapath terms
  logic                  p_below;
  logic                  t_below;
  logic [POWER_BITS-1:0] dp_w;
  logic [TIME_BITS-1:0]  dt_w;
  logic [NUM_BITS-1:0]   num_w;
  logic                  div_done;
  logic [NUM_BITS-1:0]   div_quot;
  logic                  dt_zero;
  logic [NUM_BITS-1:0]   q_eff;
  logic                  corr_neg;
  logic [NUM_BITS:0]     sum_w;
  logic [NUM_BITS:0]     dif_w;
  logic                  below_zero;
  logic [TIME_BITS:0]    time_add;
  logic [SUM_BITS:0]     energy_add;
  logic                  mul_done;
  logic [SUM_BITS-1:0]   mul_prod;

  assign in_beat = in_chan.valid & in_ready;

  // Spans against the older sample, taken straight off the input beat
  always_comb begin
    p_below = (in_chan.power_mw < older_p_r);
    t_below = (in_chan.time_ns < older_t_r);
    dp_w    = p_below ? (older_p_r - in_chan.power_mw) : (in_chan.power_mw - older_p_r);
    dt_w    = t_below ? (older_t_r - in_chan.time_ns) : (in_chan.time_ns - older_t_r);
  end

  // Correction numerator, registered inside the divider
  assign num_w = {{POWER_BITS{1'b0}}, cap_r} * {{CAP_BITS{1'b0}}, dp_r};

  // Signed sum of middle power and truncated quotient
  always_comb begin
    dt_zero    = (dt_r == '0);
    q_eff      = dt_zero ? '0 : div_quot;
    corr_neg   = dp_neg_r ^ dt_neg_r;
    sum_w      = {1'b0, q_eff} + (NUM_BITS+1)'(newer_p_r);
    dif_w      = (NUM_BITS+1)'(newer_p_r) - {1'b0, q_eff};
    below_zero = corr_neg && (q_eff > NUM_BITS'(newer_p_r));
  end

  assign count_active = (fill_r >= FILL_COUNTED) && (corr_r > idle_r);

  // Saturating adders of the totals
  assign time_add   = {1'b0, time_sum_r} + {1'b0, iv_r};
  assign energy_add = {1'b0, energy_r} + {1'b0, mul_prod};

  pslc_ser_div #(
    .N_BITS (NUM_BITS),
    .D_BITS (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_w),
    .den   (dt_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  pslc_ser_mul #(
    .A_BITS (SUM_BITS),
    .B_BITS (POWER_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (iv_r),
    .b       (corr_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_chan.valid) state_nxt = S_PREP;
      S_PREP:  state_nxt = (fill_r >= FILL_CORRECT) ? S_DIV : S_DONE;
      S_DIV:   if (div_done) state_nxt = S_CORR;
      S_CORR:  state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_CHECK;
      S_CHECK: state_nxt = count_active ? S_MUL : S_DONE;
      S_MUL:   if (mul_done) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_chan.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_PREP:  div_start = (fill_r >= FILL_CORRECT);
      S_CHECK: mul_start = count_active;
      S_DONE:  out_load  = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // State, configuration, history and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cap_r      <= CAP_RESET;
      max_r      <= POWER_BITS'(MAX_POWER_RESET);
      idle_r     <= POWER_BITS'(IDLE_RESET);
      older_p_r  <= '0;
      newer_p_r  <= '0;
      older_t_r  <= '0;
      newer_t_r  <= '0;
      fill_r     <= '0;
      time_sum_r <= '0;
      energy_r   <= '0;
      min_r      <= INTERVAL_RESET;
      act_cnt_r  <= '0;
      disc_cnt_r <= '0;
      act_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // config beat; unknown indexes are dropped
      if (cfg_chan.valid) begin
        unique case (cfg_reg_t'(cfg_chan.index))
          REG_CAPACITANCE: cap_r  <= cfg_chan.data[CAP_BITS-1:0];
          REG_MAX_POWER:   max_r  <= cfg_chan.data[POWER_BITS-1:0];
          REG_ACTIVE_IDLE: idle_r <= cfg_chan.data[POWER_BITS-1:0];
          default: ;
        endcase
      end

      if (in_beat) act_r <= 1'b0;

      // accumulate from the third corrected value on
      if (state_r == S_CHECK && fill_r >= FILL_COUNTED) begin
        if (count_active) begin
          act_r <= 1'b1;
          if (act_cnt_r != '1) act_cnt_r <= act_cnt_r + 1'b1;
          if (iv_r < {{(TIME_BITS-INTERVAL_BITS){1'b0}}, min_r}) begin
            min_r <= iv_r[INTERVAL_BITS-1:0];
          end
          time_sum_r <= time_add[TIME_BITS] ? '1 : time_add[TIME_BITS-1:0];
        end else if (disc_cnt_r != '1) begin
          disc_cnt_r <= disc_cnt_r + 1'b1;
        end
      end

      if (state_r == S_MUL && mul_done) begin
        energy_r <= energy_add[SUM_BITS] ? '1 : energy_add[SUM_BITS-1:0];
      end

      // retire: shift history, hand the result to the output register
      if (out_load) begin
        older_p_r <= newer_p_r;
        older_t_r <= newer_t_r;
        newer_p_r <= p_r;
        newer_t_r <= t_r;
        if (fill_r < FILL_MAX) fill_r <= fill_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-sample payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      p_r      <= in_chan.power_mw;
      t_r      <= in_chan.time_ns;
      dp_r     <= dp_w;
      dp_neg_r <= p_below;
      dt_r     <= dt_w;
      dt_neg_r <= t_below;
      corr_r   <= '0;
      fault_r  <= 1'b0;
    end
    if (state_r == S_CORR) begin
      raw_r   <= corr_neg ? dif_w : sum_w;
      zero_r  <= below_zero;
      fault_r <= dt_zero;
      iv_r    <= (newer_t_r >= older_t_r) ? (newer_t_r - older_t_r) : '0;
    end
    // clamp to zero and the power cap
    if (state_r == S_CLAMP) begin
      if (zero_r) corr_r <= '0;
      else if (raw_r > (NUM_BITS+1)'(max_r)) corr_r <= max_r;
      else corr_r <= raw_r[POWER_BITS-1:0];
    end
    if (out_load) begin
      o_corr_valid_r <= (fill_r >= FILL_CORRECT);
      o_corr_r       <= corr_r;
      o_act_r        <= act_r;
      o_fault_r      <= fault_r;
      o_time_r       <= time_sum_r;
      o_energy_r     <= energy_r;
      o_min_r        <= min_r;
      o_act_cnt_r    <= act_cnt_r;
      o_disc_cnt_r   <= disc_cnt_r;
    end
  end

  // Channel hookup
  assign in_chan.ready               = in_ready;
  assign cfg_chan.ready              = 1'b1;
  assign out_chan.valid              = out_valid_r;
  assign out_chan.corrected_valid    = o_corr_valid_r;
  assign out_chan.corrected_power_mw = o_corr_r;
  assign out_chan.is_active          = o_act_r;
  assign out_chan.divide_fault       = o_fault_r;
  assign out_chan.active_time_ns     = o_time_r;
  assign out_chan.active_energy      = o_energy_r;
  assign out_chan.min_interval_ns    = o_min_r;
  assign out_chan.active_count       = o_act_cnt_r;
  assign out_chan.discarded_count    = o_disc_cnt_r;

  // Checks
  `include "power_sample_lag_correction_top_assert.svh"

  `PSLC_ASSERT_NEXT(a_beat_starts_item, in_beat, state_r == S_PREP, "sample beat did not start work")
  `PSLC_ASSERT_NOW(a_div_done_in_div, div_done, state_r == S_DIV, "divider finished outside its state")
  `PSLC_ASSERT_NOW(a_mul_done_in_mul, mul_done, state_r == S_MUL, "multiplier finished outside its state")
  `PSLC_ASSERT_NEXT(a_stall_holds_result, state_r == S_DONE && out_valid_r && !out_chan.ready, state_r == S_DONE && out_valid_r, "result retired over a stalled beat")

endmodule

/* src/pslc_ser_mul.sv */
// Bit-serial saturating multiplier: one multiplier bit per cycle, MSB first.
// Depends on pslc_pkg for default widths.
module pslc_ser_mul
  import pslc_pkg::*;
#(
  parameter int A_BITS = SUM_BITS,
  parameter int B_BITS = POWER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [A_BITS-1:0] a,
  input  logic [B_BITS-1:0] b,
  output logic              done,
  output logic [A_BITS-1:0] product
);

  localparam int CNT_BITS = $clog2(B_BITS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [A_BITS-1:0]   a_r;
  logic [B_BITS-1:0]   b_r;
  logic [A_BITS-1:0]   acc_r;
  logic                sat_r;

  logic [A_BITS+1:0]   step_sum;
  logic                step_over;

  // Horner step: acc*2 + (bit ? a : 0); acc stays below 2^A_BITS unless saturated
  always_comb begin
    step_sum  = {1'b0, acc_r, 1'b0} + (b_r[B_BITS-1] ? {2'b00, a_r} : '0);
    step_over = |step_sum[A_BITS+1:A_BITS];
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(B_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand shift and accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      acc_r <= step_sum[A_BITS-1:0];
      sat_r <= sat_r | step_over;
      b_r   <= {b_r[B_BITS-2:0], 1'b0};
    end
  end

  assign done    = done_r;
  assign product = sat_r ? '1 : acc_r;

endmodule

/* src/pslc_ser_div.sv */
// Restoring radix-2 divider: one quotient bit per cycle, MSB first.
// Depends on pslc_pkg for default widths.
module pslc_ser_div
  import pslc_pkg::*;
#(
  parameter int N_BITS = CAP_BITS + POWER_BITS_DEF,
  parameter int D_BITS = TIME_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [N_BITS-1:0] num,
  input  logic [D_BITS-1:0] den,
  output logic              done,
  output logic [N_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(N_BITS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [D_BITS-1:0]   den_r;
  logic [D_BITS-1:0]   rem_r;
  logic [N_BITS-1:0]   qn_r;   // numerator bits out at the top, quotient bits in

  logic [D_BITS:0]     trial;
  logic [D_BITS:0]     trial_sub;
  logic                fits;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    trial     = {rem_r, qn_r[N_BITS-1]};
    trial_sub = trial - {1'b0, den_r};
    fits      = (trial >= {1'b0, den_r});
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(N_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      qn_r  <= num;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[D_BITS-1:0] : trial[D_BITS-1:0];
      qn_r  <= {qn_r[N_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = qn_r;

endmodule
